@@ hw/rtl/pmsfr_pkg.sv @@
package pmsfr_pkg;

   // receiver phases plus the two payload read-out steps
   typedef enum logic [8:0] {
      PH_HUNT1    = 9'b000000001,
      PH_HUNT2    = 9'b000000010,
      PH_LENHI    = 9'b000000100,
      PH_LENLO    = 9'b000001000,
      PH_DATA     = 9'b000010000,
      PH_SUMHI    = 9'b000100000,
      PH_SUMLO    = 9'b001000000,
      PH_EMIT_RD  = 9'b010000000,
      PH_EMIT_OUT = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_LEN     = 2'd1,
      ST_SUM     = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic CSR_PAYLOAD_WORDS = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [7:0]  START_FIRST   = 8'h42;
   localparam logic [7:0]  START_SECOND  = 8'h4D;
   localparam logic [4:0]  WORDS_RESET   = 5'd13;
   localparam logic [11:0] TIMEOUT_RESET = 12'd2300;

endpackage

@@ hw/rtl/pmsfr_ram.sv @@
module pmsfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/particle_sensor_frame_receiver.sv @@
// Particle sensor frame receiver.
// req_ channel: one transaction per received serial byte (req_tuser = 0) or per
// millisecond tick (req_tuser = 1). Frames are 0x42 0x4D, length, payload and
// checksum, all 16-bit fields big-endian.
// rsp_ channel: a good frame yields one transaction per 16-bit payload word,
// rsp_tlast on the final word; a length error, checksum error or idle timeout
// yields a single transaction with rsp_tlast set and zero data.
// csr_ channel: index 0 payload_words, index 1 timeout_ticks; always ready.
// Throughput: one input transaction per cycle while the output register is
// free or being drained. Error results appear in the cycle after the byte or tick.
// After the checksum byte the payload is read back from the word RAM: a
// registered read in PH_EMIT_RD, then one word per cycle while rsp_tready is high;
// no input is taken during that read-out. The RAM's single read port sets this.
// A stalled receiver holds the output register and blocks req_tready.
// Reset returns the receiver to hunting for the first start byte and restores
// the register defaults (13 words, 2300 ticks); the payload RAM is not cleared.
module particle_sensor_frame_receiver #(
   parameter int MAX_WORDS = 16,
   localparam int WW = $clog2(MAX_WORDS + 1),
   localparam int BW = WW + 1,
   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] command

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] word_index, [19:4] word_value, [23:20] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,   // last

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);

   pmsfr_pkg::phase_type  state_ff, state_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            len_hi_ff, len_hi_in;
   logic [7:0]            chk_hi_ff, chk_hi_in;
   logic [7:0]            data_hi_ff, data_hi_in;
   logic [BW-1:0]         pos_ff, pos_in;
   logic [11:0]           idle_ff, idle_in;
   logic [WW-1:0]         emit_idx_ff, emit_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   pmsfr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_index_ff, rsp_index_in;
   logic [15:0]           rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [4:0]            words_cfg_ff;
   logic [11:0]           timeout_cfg_ff;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [15:0]           ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [15:0]           ram_rd_data;

   logic                  out_free;
   logic                  run_phase;
   logic                  accept;
   logic [WW-1:0]         words;
   logic [BW-1:0]         pos_next;
   logic [WW-1:0]         idx_next;
   logic                  err;
   pmsfr_pkg::status_type err_code;

   pmsfr_ram #(
      .WIDTH (16),
      .DEPTH (MAX_WORDS)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // clamp the word count into 1..MAX_WORDS
   always_comb begin
      if (words_cfg_ff == 5'd0) begin
         words = WW'(1);
      end else if ({1'b0, words_cfg_ff} > 6'(MAX_WORDS)) begin
         words = WW'(MAX_WORDS);
      end else begin
         words = WW'(words_cfg_ff);
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign run_phase  = (state_ff != pmsfr_pkg::PH_EMIT_RD) &&
                       (state_ff != pmsfr_pkg::PH_EMIT_OUT);
   assign req_tready = run_phase && out_free;
   assign accept     = req_tvalid && req_tready;
   assign pos_next   = pos_ff + BW'(1);
   assign idx_next   = emit_idx_ff + WW'(1);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      len_hi_in     = len_hi_ff;
      chk_hi_in     = chk_hi_ff;
      data_hi_in    = data_hi_ff;
      pos_in        = pos_ff;
      idle_in       = idle_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(pos_ff[BW-1:1]);
      ram_wr_data   = {data_hi_ff, req_tdata};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(emit_idx_ff);
      err           = 1'b0;
      err_code      = pmsfr_pkg::ST_OK;

      if (accept && req_tuser == pmsfr_pkg::CMD_TICK) begin
         if (idle_ff >= timeout_cfg_ff) begin
            idle_in  = 12'd0;
            err      = 1'b1;
            err_code = pmsfr_pkg::ST_TIMEOUT;
         end else begin
            idle_in = idle_ff + 12'd1;
         end
      end else if (accept) begin
         idle_in = 12'd0;
      end

      unique case (state_ff)
         pmsfr_pkg::PH_HUNT1: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE &&
                req_tdata == pmsfr_pkg::START_FIRST) begin
               sum_in   = {8'd0, pmsfr_pkg::START_FIRST};
               state_in = pmsfr_pkg::PH_HUNT2;
            end
         end
         pmsfr_pkg::PH_HUNT2: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE) begin
               if (req_tdata == pmsfr_pkg::START_SECOND) begin
                  sum_in   = sum_ff + {8'd0, req_tdata};
                  state_in = pmsfr_pkg::PH_LENHI;
               end else begin
                  state_in = pmsfr_pkg::PH_HUNT1;
               end
            end
         end
         pmsfr_pkg::PH_LENHI: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE) begin
               len_hi_in = req_tdata;
               sum_in    = sum_ff + {8'd0, req_tdata};
               state_in  = pmsfr_pkg::PH_LENLO;
            end
         end
         pmsfr_pkg::PH_LENLO: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE) begin
               sum_in = sum_ff + {8'd0, req_tdata};
               if ({len_hi_ff, req_tdata} != 16'({words, 1'b0}) + 16'd2) begin
                  err      = 1'b1;
                  err_code = pmsfr_pkg::ST_LEN;
               end else begin
                  pos_in   = '0;
                  state_in = pmsfr_pkg::PH_DATA;
               end
            end
         end
         pmsfr_pkg::PH_DATA: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE) begin
               sum_in = sum_ff + {8'd0, req_tdata};
               // hold the high byte, write the word on its low byte
               if (pos_ff[0]) begin
                  ram_wr_en = 1'b1;
               end else begin
                  data_hi_in = req_tdata;
               end
               pos_in = pos_next;
               if (pos_next >= {words, 1'b0}) begin
                  pos_in   = '0;
                  state_in = pmsfr_pkg::PH_SUMHI;
               end
            end
         end
         pmsfr_pkg::PH_SUMHI: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE) begin
               chk_hi_in = req_tdata;
               state_in  = pmsfr_pkg::PH_SUMLO;
            end
         end
         pmsfr_pkg::PH_SUMLO: begin
            if (accept && req_tuser == pmsfr_pkg::CMD_BYTE) begin
               if ({chk_hi_ff, req_tdata} != sum_ff) begin
                  err      = 1'b1;
                  err_code = pmsfr_pkg::ST_SUM;
               end else begin
                  emit_idx_in = '0;
                  state_in    = pmsfr_pkg::PH_EMIT_RD;
               end
            end
         end
         pmsfr_pkg::PH_EMIT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(emit_idx_ff);
            state_in    = pmsfr_pkg::PH_EMIT_OUT;
         end
         pmsfr_pkg::PH_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pmsfr_pkg::ST_OK;
               rsp_index_in  = 4'(emit_idx_ff);
               rsp_value_in  = ram_rd_data;
               rsp_last_in   = (idx_next == words);
               if (idx_next == words) begin
                  state_in = pmsfr_pkg::PH_HUNT1;
               end else begin
                  // fetch the next word while this one goes out
                  emit_idx_in = idx_next;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(idx_next);
               end
            end
         end
         default: begin
            state_in = pmsfr_pkg::PH_HUNT1;
         end
      endcase

      if (err) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = err_code;
         rsp_index_in  = 4'd0;
         rsp_value_in  = 16'd0;
         rsp_last_in   = 1'b1;
         state_in      = pmsfr_pkg::PH_HUNT1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pmsfr_pkg::PH_HUNT1;
         idle_ff        <= 12'd0;
         rsp_valid_ff   <= 1'b0;
         words_cfg_ff   <= pmsfr_pkg::WORDS_RESET;
         timeout_cfg_ff <= pmsfr_pkg::TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pmsfr_pkg::CSR_PAYLOAD_WORDS: words_cfg_ff   <= csr_data[4:0];
               pmsfr_pkg::CSR_TIMEOUT_TICKS: timeout_cfg_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      len_hi_ff     <= len_hi_in;
      chk_hi_ff     <= chk_hi_in;
      data_hi_ff    <= data_hi_in;
      pos_ff        <= pos_in;
      emit_idx_ff   <= emit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_value_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
